### rtl/core/tcmc_pkg.sv
// Shared types, widths and codes of the timing coincidence match counter.
package tcmc_pkg;

  // Store depth and derived index widths
  localparam int unsigned LIST_DEPTH = 32;
  localparam int unsigned IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned FILL_W     = $clog2(LIST_DEPTH + 1);

  // Field and datapath widths
  localparam int unsigned OP_W      = 2;
  localparam int unsigned STAMP_W   = 40;
  localparam int unsigned HALF_W    = STAMP_W / 2;
  localparam int unsigned TICK_W    = 16;
  localparam int unsigned PPROD_W   = HALF_W + TICK_W;
  localparam int unsigned PROD_W    = STAMP_W + TICK_W;
  localparam int unsigned TIME_W    = PROD_W + 2;
  localparam int unsigned CMP_W     = TIME_W + 1;
  localparam int unsigned OFFSET_W  = 32;
  localparam int unsigned WIN_W     = 21;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned APB_AW    = 5;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(LIST_DEPTH);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(LIST_DEPTH);
  localparam logic [POS_W-1:0]  POS_MAX   = POS_W'(LIST_DEPTH - 1);

  // Opcodes
  localparam logic [OP_W-1:0] OP_LOAD_HIT   = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_PULSE = 2'd1;
  localparam logic [OP_W-1:0] OP_EVAL       = 2'd2;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_HIT_TICK     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PULSE_TICK   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PULSE_OFFSET = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LOW   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_HIGH  = 3'd4;

  // Register reset values
  localparam logic [TICK_W-1:0]   HIT_TICK_RST   = 16'd25;
  localparam logic [TICK_W-1:0]   PULSE_TICK_RST = 16'd1000;
  localparam logic [OFFSET_W-1:0] OFFSET_RST     = '0;
  localparam logic [WIN_W-1:0]    WIN_LOW_RST    = WIN_W'(-300000);
  localparam logic [WIN_W-1:0]    WIN_HIGH_RST   = WIN_W'(300000);

  // Result side codes
  localparam logic SIDE_PULSE = 1'b0;
  localparam logic SIDE_HIT   = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [STAMP_W-1:0] stamp;
  } in_item_t;

  typedef struct packed {
    logic             side;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] match_count;
    logic             overflow;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic [TICK_W-1:0]   hit_tick;
    logic [TICK_W-1:0]   pulse_tick;
    logic [OFFSET_W-1:0] pulse_offset;
    logic [WIN_W-1:0]    window_low;
    logic [WIN_W-1:0]    window_high;
  } cfg_t;

  typedef struct packed {
    logic             mul_en;
    logic             load_pulse;
    logic             wr_en;
    logic             scan;
    logic             cnt_clr;
    logic             emit;
    logic             last;
    logic             clear;
    logic             side;
    logic [IDX_W-1:0] ref_idx;
    logic [IDX_W-1:0] oth_idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [FILL_W-1:0] hit_fill;
    logic [FILL_W-1:0] pulse_fill;
    logic              out_free;
  } ctrl_status_t;

endpackage

### rtl/core/timing_coincidence_match_counter_top.sv
// Top level of the timing coincidence match counter.
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  --------------------------------
//  in       sink       in_valid_i / in_ready_o   in_data_i  (op, stamp)
//  out      source     out_valid_o / out_ready_i out_data_o (side, position,
//                                                 match_count, overflow, last)
//  cfg      APB slave  psel/penable/pwrite       paddr, pwdata, prdata, pready
//
// On a load beat the stamp is multiplied by the tick period as two 20x16
// partial products, which are registered, then recombined, offset (pulse
// stamps only) and written to its store. An evaluate beat walks each
// reference element through ST_REF, ST_SCAN, ST_DRAIN and ST_EMIT, and ends
// with a clear in ST_DONE; an element whose other store is empty goes from
// ST_REF straight to ST_EMIT. Each reference element scans the other store
// one entry a cycle through the single read port of its RAM. Op 3 is taken
// and does nothing. Reset is asynchronous, active low; in_ready_o rises the
// cycle after reset is released. No clearing pass: the fill counts bound
// every store read. A result waits in the output register; the scan of the
// next element goes on meanwhile and stalls only when it needs that register.

module timing_coincidence_match_counter_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input beats
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  tcmc_pkg::in_item_t          in_data_i,
  // result beats
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output tcmc_pkg::out_item_t         out_data_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcmc_pkg::APB_AW-1:0] paddr,
  input  logic [tcmc_pkg::APB_DW-1:0] pwdata,
  output logic [tcmc_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  tcmc_pkg::cfg_t         cfg;
  tcmc_pkg::ctrl_cmd_t    cmd;
  tcmc_pkg::ctrl_status_t status;

  // Tick periods, pulse offset and window edges
  tcmc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // Sequencer: decodes the op, then walks pulses against hits and hits
  // against pulses, one compare per cycle while scanning
  tcmc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_op_i   (in_data_i.op),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // Conversion, stores, window compare, count and result register
  tcmc_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_stamp_i (in_data_i.stamp),
    .cfg_i      (cfg),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

### rtl/core/tcmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcmc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/tcmc_cfg_regs.sv
// APB-style configuration register file.
module tcmc_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcmc_pkg::APB_AW-1:0] paddr,
  input  logic [tcmc_pkg::APB_DW-1:0] pwdata,
  output logic [tcmc_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output tcmc_pkg::cfg_t              cfg_o
);

  tcmc_pkg::cfg_t                  cfg_q;
  logic [tcmc_pkg::REG_IDX_W-1:0]  reg_idx;
  logic                            wr_en;

  assign reg_idx = paddr[tcmc_pkg::APB_AW-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hit_tick     <= tcmc_pkg::HIT_TICK_RST;
      cfg_q.pulse_tick   <= tcmc_pkg::PULSE_TICK_RST;
      cfg_q.pulse_offset <= tcmc_pkg::OFFSET_RST;
      cfg_q.window_low   <= tcmc_pkg::WIN_LOW_RST;
      cfg_q.window_high  <= tcmc_pkg::WIN_HIGH_RST;
    end else if (wr_en) begin
      case (reg_idx)
        tcmc_pkg::REG_HIT_TICK:     cfg_q.hit_tick     <= pwdata[tcmc_pkg::TICK_W-1:0];
        tcmc_pkg::REG_PULSE_TICK:   cfg_q.pulse_tick   <= pwdata[tcmc_pkg::TICK_W-1:0];
        tcmc_pkg::REG_PULSE_OFFSET: cfg_q.pulse_offset <= pwdata[tcmc_pkg::OFFSET_W-1:0];
        tcmc_pkg::REG_WINDOW_LOW:   cfg_q.window_low   <= pwdata[tcmc_pkg::WIN_W-1:0];
        tcmc_pkg::REG_WINDOW_HIGH:  cfg_q.window_high  <= pwdata[tcmc_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tcmc_pkg::REG_HIT_TICK:     prdata = tcmc_pkg::APB_DW'(cfg_q.hit_tick);
      tcmc_pkg::REG_PULSE_TICK:   prdata = tcmc_pkg::APB_DW'(cfg_q.pulse_tick);
      tcmc_pkg::REG_PULSE_OFFSET: prdata = tcmc_pkg::APB_DW'(cfg_q.pulse_offset);
      tcmc_pkg::REG_WINDOW_LOW:   prdata = tcmc_pkg::APB_DW'(cfg_q.window_low);
      tcmc_pkg::REG_WINDOW_HIGH:  prdata = tcmc_pkg::APB_DW'(cfg_q.window_high);
      default:                    prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/tcmc_datapath.sv
// Datapath: stamp conversion, time stores, window compare, count and result register.
module tcmc_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [tcmc_pkg::STAMP_W-1:0] in_stamp_i,
  input  tcmc_pkg::cfg_t               cfg_i,
  input  tcmc_pkg::ctrl_cmd_t          cmd_i,
  output tcmc_pkg::ctrl_status_t       status_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output tcmc_pkg::out_item_t          out_data_o
);

  localparam int unsigned TW = tcmc_pkg::TIME_W;
  localparam int unsigned CW = tcmc_pkg::CMP_W;

  // Conversion stage 1: two half-width partial products
  logic [tcmc_pkg::TICK_W-1:0]  tick;
  logic [tcmc_pkg::PPROD_W-1:0] p_lo_d, p_hi_d, p_lo_q, p_hi_q;
  logic                         ld_pulse_q;

  assign tick   = cmd_i.load_pulse ? cfg_i.pulse_tick : cfg_i.hit_tick;
  assign p_lo_d = tcmc_pkg::PPROD_W'(in_stamp_i[tcmc_pkg::HALF_W-1:0]) *
                  tcmc_pkg::PPROD_W'(tick);
  assign p_hi_d = tcmc_pkg::PPROD_W'(in_stamp_i[tcmc_pkg::STAMP_W-1:tcmc_pkg::HALF_W]) *
                  tcmc_pkg::PPROD_W'(tick);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      p_lo_q     <= p_lo_d;
      p_hi_q     <= p_hi_d;
      ld_pulse_q <= cmd_i.load_pulse;
    end
  end

  // Conversion stage 2: recombine and add the pulse offset
  logic [tcmc_pkg::PROD_W-1:0] prod;
  logic [TW-1:0]               off_ext, wr_time;

  assign prod    = {p_hi_q, {tcmc_pkg::HALF_W{1'b0}}} + tcmc_pkg::PROD_W'(p_lo_q);
  assign off_ext = ld_pulse_q ?
                   {{(TW - tcmc_pkg::OFFSET_W){cfg_i.pulse_offset[tcmc_pkg::OFFSET_W-1]}},
                    cfg_i.pulse_offset} : '0;
  assign wr_time = {{(TW - tcmc_pkg::PROD_W){1'b0}}, prod} + off_ext;

  // Fill counts and overflow flag
  logic [tcmc_pkg::FILL_W-1:0] hit_fill_q, pulse_fill_q;
  logic                        dropped_q;
  logic                        hit_we, pulse_we;

  assign hit_we   = cmd_i.wr_en & ~ld_pulse_q & (hit_fill_q != tcmc_pkg::FILL_FULL);
  assign pulse_we = cmd_i.wr_en &  ld_pulse_q & (pulse_fill_q != tcmc_pkg::FILL_FULL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_fill_q   <= '0;
      pulse_fill_q <= '0;
      dropped_q    <= 1'b0;
    end else if (cmd_i.clear) begin
      hit_fill_q   <= '0;
      pulse_fill_q <= '0;
      dropped_q    <= 1'b0;
    end else if (cmd_i.wr_en) begin
      if (hit_we) begin
        hit_fill_q <= hit_fill_q + tcmc_pkg::FILL_W'(1);
      end else if (pulse_we) begin
        pulse_fill_q <= pulse_fill_q + tcmc_pkg::FILL_W'(1);
      end else begin
        dropped_q <= 1'b1;
      end
    end
  end

  // Time stores; the reference reads at ref_idx, the other list scans at oth_idx
  logic [tcmc_pkg::IDX_W-1:0] hit_raddr, pulse_raddr;
  logic [TW-1:0]              hit_rdata, pulse_rdata;

  assign hit_raddr   = (cmd_i.side == tcmc_pkg::SIDE_PULSE) ? cmd_i.oth_idx : cmd_i.ref_idx;
  assign pulse_raddr = (cmd_i.side == tcmc_pkg::SIDE_PULSE) ? cmd_i.ref_idx : cmd_i.oth_idx;

  tcmc_ram #(
    .WIDTH(TW),
    .DEPTH(tcmc_pkg::LIST_DEPTH)
  ) u_hit_ram (
    .clk_i  (clk_i),
    .we_i   (hit_we),
    .waddr_i(hit_fill_q[tcmc_pkg::IDX_W-1:0]),
    .wdata_i(wr_time),
    .raddr_i(hit_raddr),
    .rdata_o(hit_rdata)
  );

  tcmc_ram #(
    .WIDTH(TW),
    .DEPTH(tcmc_pkg::LIST_DEPTH)
  ) u_pulse_ram (
    .clk_i  (clk_i),
    .we_i   (pulse_we),
    .waddr_i(pulse_fill_q[tcmc_pkg::IDX_W-1:0]),
    .wdata_i(wr_time),
    .raddr_i(pulse_raddr),
    .rdata_o(pulse_rdata)
  );

  // Window compare on the registered read data: ref+lo < t <= ref+hi
  logic [TW-1:0]        ref_t, oth_t;
  logic signed [CW-1:0] ref_ext, oth_ext, lo_ext, hi_ext, edge_lo, edge_hi;
  logic                 match;
  logic                 cmp_vld_q;
  logic [tcmc_pkg::CNT_W-1:0] cnt_q;

  assign ref_t   = (cmd_i.side == tcmc_pkg::SIDE_PULSE) ? pulse_rdata : hit_rdata;
  assign oth_t   = (cmd_i.side == tcmc_pkg::SIDE_PULSE) ? hit_rdata : pulse_rdata;
  assign ref_ext = {ref_t[TW-1], ref_t};
  assign oth_ext = {oth_t[TW-1], oth_t};
  assign lo_ext  = {{(CW - tcmc_pkg::WIN_W){cfg_i.window_low[tcmc_pkg::WIN_W-1]}},
                    cfg_i.window_low};
  assign hi_ext  = {{(CW - tcmc_pkg::WIN_W){cfg_i.window_high[tcmc_pkg::WIN_W-1]}},
                    cfg_i.window_high};
  assign edge_lo = ref_ext + lo_ext;
  assign edge_hi = ref_ext + hi_ext;
  assign match   = (oth_ext > edge_lo) && (oth_ext <= edge_hi);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_vld_q <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.scan;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmp_vld_q && match) begin
      cnt_q <= cnt_q + tcmc_pkg::CNT_W'(1);
    end
  end

  // Result register
  logic                out_valid_q;
  tcmc_pkg::out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.side        <= cmd_i.side;
      out_q.position    <= tcmc_pkg::POS_W'(cmd_i.ref_idx);
      out_q.match_count <= cnt_q;
      out_q.overflow    <= dropped_q;
      out_q.last        <= cmd_i.last;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_data_o          = out_q;
  assign status_o.hit_fill   = hit_fill_q;
  assign status_o.pulse_fill = pulse_fill_q;
  assign status_o.out_free   = ~out_valid_q | out_ready_i;

endmodule

### rtl/core/tcmc_ctrl.sv
// Controller: load sequencing and the evaluation walk over both stores.
module tcmc_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [tcmc_pkg::OP_W-1:0] in_op_i,
  output logic                      in_ready_o,
  input  tcmc_pkg::ctrl_status_t    status_i,
  output tcmc_pkg::ctrl_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_REF,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT,
    ST_DONE
  } state_e;

  state_e                      state_q, state_d;
  logic                        side_q, side_d;
  logic [tcmc_pkg::FILL_W-1:0] i_q, i_d, j_q, j_d;
  logic                        in_ready_q, in_ready_d;

  logic                        accept;
  logic [tcmc_pkg::FILL_W-1:0] ref_fill, oth_fill, i_nxt, j_nxt;
  tcmc_pkg::ctrl_cmd_t         cmd;

  assign accept   = in_valid_i & in_ready_q;
  assign ref_fill = (side_q == tcmc_pkg::SIDE_HIT) ? status_i.hit_fill : status_i.pulse_fill;
  assign oth_fill = (side_q == tcmc_pkg::SIDE_HIT) ? status_i.pulse_fill : status_i.hit_fill;
  assign i_nxt    = i_q + tcmc_pkg::FILL_W'(1);
  assign j_nxt    = j_q + tcmc_pkg::FILL_W'(1);

  always_comb begin
    state_d = state_q;
    side_d  = side_q;
    i_d     = i_q;
    j_d     = j_q;
    cmd     = '0;
    cmd.side    = side_q;
    cmd.ref_idx = i_q[tcmc_pkg::IDX_W-1:0];
    cmd.oth_idx = j_q[tcmc_pkg::IDX_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_op_i)
            tcmc_pkg::OP_LOAD_HIT: begin
              cmd.mul_en = 1'b1;
              state_d    = ST_LOAD;
            end
            tcmc_pkg::OP_LOAD_PULSE: begin
              cmd.mul_en     = 1'b1;
              cmd.load_pulse = 1'b1;
              state_d        = ST_LOAD;
            end
            tcmc_pkg::OP_EVAL: begin
              side_d  = tcmc_pkg::SIDE_PULSE;
              i_d     = '0;
              state_d = ST_REF;
            end
            default: ;
          endcase
        end
      end
      ST_LOAD: begin
        cmd.wr_en = 1'b1;
        state_d   = ST_IDLE;
      end
      ST_REF: begin
        if (i_q == ref_fill) begin
          if (side_q == tcmc_pkg::SIDE_PULSE) begin
            side_d = tcmc_pkg::SIDE_HIT;
            i_d    = '0;
          end else begin
            state_d = ST_DONE;
          end
        end else begin
          cmd.cnt_clr = 1'b1;
          j_d         = '0;
          state_d     = (oth_fill == '0) ? ST_EMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (j_nxt == oth_fill) begin
          state_d = ST_DRAIN;
        end else begin
          j_d = j_nxt;
        end
      end
      ST_DRAIN: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = (i_nxt == ref_fill) &&
                     ((side_q == tcmc_pkg::SIDE_HIT) || (status_i.hit_fill == '0));
          i_d      = i_nxt;
          state_d  = ST_REF;
        end
      end
      ST_DONE: begin
        cmd.clear = 1'b1;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    in_ready_d = (state_d == ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      side_q     <= tcmc_pkg::SIDE_PULSE;
      i_q        <= '0;
      j_q        <= '0;
      in_ready_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      side_q     <= side_d;
      i_q        <= i_d;
      j_q        <= j_d;
      in_ready_q <= in_ready_d;
    end
  end

  assign in_ready_o = in_ready_q;
  assign cmd_o      = cmd;

endmodule

### rtl/core/tcmc_checker.sv
// Port-level checker for the timing coincidence match counter, bound to the top level.
module tcmc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input tcmc_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input tcmc_pkg::out_item_t out_data_o
);

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // Every load or evaluate beat keeps the input closed for the next cycle
  a_busy_after_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o &&
    (in_data_i.op == tcmc_pkg::OP_LOAD_HIT || in_data_i.op == tcmc_pkg::OP_LOAD_PULSE ||
     in_data_i.op == tcmc_pkg::OP_EVAL) |=> !in_ready_o)
    else $error("input accepted during load or evaluation");

  // New results only appear while an evaluation is running
  a_result_in_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_ready_o)
    else $error("result produced while idle");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.match_count <= tcmc_pkg::CNT_MAX)
    else $error("match count beyond store depth");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.position <= tcmc_pkg::POS_MAX)
    else $error("position beyond store depth");

endmodule

bind timing_coincidence_match_counter_top tcmc_checker u_tcmc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
